// ===== src/i2cebm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cebm_pkg: shared types and codes of the i2c eeprom byte master
// beat layouts, command kinds, register indexes, error codes and bus phases
// ----------------------------------------------------------------------------
package i2cebm_pkg;

    // command kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_HALF_PERIOD   = 1'd0;
    localparam logic [0:0] CFG_DEVICE_SELECT = 1'd1;

    localparam int unsigned HALF_W = 10;
    localparam int unsigned DEV_W  = 7;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET   = 10'd50;
    localparam logic [DEV_W-1:0]  DEVICE_SELECT_RESET = 7'd80;

    // error codes
    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_ID      = 3'd1;
    localparam logic [2:0] ERR_ADDR    = 3'd2;
    localparam logic [2:0] ERR_DATA    = 3'd3;
    localparam logic [2:0] ERR_READ_ID = 3'd4;

    // byte stage within a transaction
    localparam logic [1:0] STG_ID      = 2'd0;
    localparam logic [1:0] STG_ADDR    = 2'd1;
    localparam logic [1:0] STG_DATA    = 2'd2;
    localparam logic [1:0] STG_READ_ID = 2'd3;

    // direction bit appended to the device id
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // bus phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START_A   = 4'd1;
    localparam logic [3:0] PH_START_B   = 4'd2;
    localparam logic [3:0] PH_BIT_LOW   = 4'd3;
    localparam logic [3:0] PH_BIT_HIGH  = 4'd4;
    localparam logic [3:0] PH_ACK_LOW   = 4'd5;
    localparam logic [3:0] PH_ACK_HIGH  = 4'd6;
    localparam logic [3:0] PH_RS_LOW    = 4'd7;
    localparam logic [3:0] PH_RS_HIGH   = 4'd8;
    localparam logic [3:0] PH_RD_LOW    = 4'd9;
    localparam logic [3:0] PH_RD_HIGH   = 4'd10;
    localparam logic [3:0] PH_NACK_LOW  = 4'd11;
    localparam logic [3:0] PH_NACK_HIGH = 4'd12;
    localparam logic [3:0] PH_STOP_A    = 4'd13;
    localparam logic [3:0] PH_STOP_B    = 4'd14;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mem_addr;
        logic [7:0] wr_data;
        logic       sda_in;
        logic       scl_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic [2:0] error_code;
    } res_t;

endpackage

// ===== src/i2c_eeprom_byte_master_core.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_core: i2c master for single byte eeprom access
// byte write and random read with clock stretching, ack check and stop on abort
// ----------------------------------------------------------------------------
// each accepted tick beat's result beat is registered and offered in the next cycle
// throughput: one tick beat per cycle while result beats are taken, set by the single state update per beat
// the result register frees as it is taken, so a new beat enters the same cycle
// reset (rst_n low, async): bus idle, lines released, no result pending,
// half period back to 50 ticks and device select back to 80
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master_core
    import i2cebm_pkg::*;
#(
    parameter int unsigned TICK_BITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    // tick beats
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    // result beats
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    // register writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [HALF_W-1:0] cfg_data
);

    // limit arithmetic runs wide enough for both the register and the counter
    localparam int unsigned LW = (TICK_BITS > HALF_W) ? TICK_BITS : HALF_W;
    localparam int unsigned CW = LW + 1;
    localparam logic [LW-1:0] CAP = LW'((64'd1 << TICK_BITS) - 64'd1);

    // configuration
    logic [HALF_W-1:0]    half_reg;
    logic [DEV_W-1:0]     dev_reg;

    // transaction state
    logic [3:0]           phase_reg,  phase_next;
    logic [7:0]           shift_reg,  shift_next;
    logic [3:0]           bitcnt_reg, bitcnt_next;
    logic [TICK_BITS-1:0] tick_reg,   tick_next;
    logic                 rd_reg,     rd_next;
    logic [7:0]           addr_reg,   addr_next;
    logic [7:0]           data_reg,   data_next;
    logic [7:0]           rbyte_reg,  rbyte_next;
    logic [2:0]           err_reg,    err_next;
    logic [1:0]           stage_reg,  stage_next;

    // result register
    logic                 res_valid_reg;
    res_t                 res_reg, res_next;

    logic                 accept;

    // phase timer
    logic [LW-1:0]        half_ext;
    logic [LW-1:0]        limit;
    logic [TICK_BITS:0]   tick_inc;
    logic                 last_tick;
    logic                 timed;
    logic                 high_phase;
    logic                 hold;
    logic                 pend;
    logic                 done;
    logic [3:0]           bitcnt_inc;

    assign cfg_ready = 1'b1;
    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // zero half period counts as one tick, large values saturate to the counter
    always_comb
    begin
        half_ext = LW'(half_reg);
        if (half_reg == '0)
        begin
            limit = LW'(1);
        end
        else if (half_ext > CAP)
        begin
            limit = CAP;
        end
        else
        begin
            limit = half_ext;
        end
    end

    assign tick_inc   = {1'b0, tick_reg} + {{TICK_BITS{1'b0}}, 1'b1};
    assign last_tick  = CW'(tick_inc) >= CW'(limit);
    assign timed      = (phase_reg != PH_IDLE) && (phase_reg <= PH_STOP_B);
    assign high_phase = (phase_reg == PH_BIT_HIGH) || (phase_reg == PH_ACK_HIGH)
                     || (phase_reg == PH_RS_HIGH)  || (phase_reg == PH_RD_HIGH)
                     || (phase_reg == PH_NACK_HIGH);
    // a high phase waits while the slave stretches scl
    assign hold       = high_phase && !cmd.scl_in;
    assign pend       = timed && !hold && last_tick;
    assign bitcnt_inc = bitcnt_reg + 4'd1;

    // next state for one tick
    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        bitcnt_next = bitcnt_reg;
        rd_next     = rd_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        rbyte_next  = rbyte_reg;
        err_next    = err_reg;
        stage_next  = stage_reg;
        done        = 1'b0;

        // timer: phases end on the last tick, the count clears at a phase end
        if (!timed)
        begin
            tick_next = '0;
        end
        else if (hold)
        begin
            tick_next = tick_reg;
        end
        else if (last_tick)
        begin
            tick_next = '0;
        end
        else
        begin
            tick_next = tick_inc[TICK_BITS-1:0];
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (cmd.kind == KIND_WRITE || cmd.kind == KIND_READ)
                begin
                    rd_next     = (cmd.kind == KIND_READ);
                    addr_next   = cmd.mem_addr;
                    data_next   = cmd.wr_data;
                    stage_next  = STG_ID;
                    shift_next  = {dev_reg, RW_WRITE};
                    bitcnt_next = '0;
                    err_next    = ERR_OK;
                    rbyte_next  = '0;
                    phase_next  = PH_START_A;
                end
            end
            PH_START_A:
            begin
                if (pend)
                begin
                    phase_next = PH_START_B;
                end
            end
            PH_START_B:
            begin
                if (pend)
                begin
                    bitcnt_next = '0;
                    phase_next  = PH_BIT_LOW;
                end
            end
            PH_BIT_LOW:
            begin
                if (pend)
                begin
                    phase_next = PH_BIT_HIGH;
                end
            end
            PH_BIT_HIGH:
            begin
                if (pend)
                begin
                    shift_next  = {shift_reg[6:0], 1'b0};
                    bitcnt_next = bitcnt_inc;
                    phase_next  = (bitcnt_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
                end
            end
            PH_ACK_LOW:
            begin
                if (pend)
                begin
                    phase_next = PH_ACK_HIGH;
                end
            end
            PH_ACK_HIGH:
            begin
                if (pend)
                begin
                    bitcnt_next = '0;
                    if (cmd.sda_in)
                    begin
                        // nack: error code follows the byte stage, always via stop
                        err_next   = {1'b0, stage_reg} + 3'd1;
                        rbyte_next = '0;
                        phase_next = PH_STOP_A;
                    end
                    else
                    begin
                        unique case (stage_reg)
                            STG_ID:
                            begin
                                stage_next = STG_ADDR;
                                shift_next = addr_reg;
                                phase_next = PH_BIT_LOW;
                            end
                            STG_ADDR:
                            begin
                                if (rd_reg)
                                begin
                                    phase_next = PH_RS_LOW;
                                end
                                else
                                begin
                                    stage_next = STG_DATA;
                                    shift_next = data_reg;
                                    phase_next = PH_BIT_LOW;
                                end
                            end
                            STG_DATA:
                            begin
                                phase_next = PH_STOP_A;
                            end
                            default:
                            begin
                                shift_next = '0;
                                phase_next = PH_RD_LOW;
                            end
                        endcase
                    end
                end
            end
            PH_RS_LOW:
            begin
                if (pend)
                begin
                    phase_next = PH_RS_HIGH;
                end
            end
            PH_RS_HIGH:
            begin
                if (pend)
                begin
                    stage_next = STG_READ_ID;
                    shift_next = {dev_reg, RW_READ};
                    phase_next = PH_START_B;
                end
            end
            PH_RD_LOW:
            begin
                if (pend)
                begin
                    phase_next = PH_RD_HIGH;
                end
            end
            PH_RD_HIGH:
            begin
                if (pend)
                begin
                    shift_next  = {shift_reg[6:0], cmd.sda_in};
                    bitcnt_next = bitcnt_inc;
                    if (bitcnt_inc >= BITS_PER_BYTE)
                    begin
                        rbyte_next = {shift_reg[6:0], cmd.sda_in};
                        phase_next = PH_NACK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_RD_LOW;
                    end
                end
            end
            PH_NACK_LOW:
            begin
                if (pend)
                begin
                    phase_next = PH_NACK_HIGH;
                end
            end
            PH_NACK_HIGH:
            begin
                if (pend)
                begin
                    phase_next = PH_STOP_A;
                end
            end
            PH_STOP_A:
            begin
                if (pend)
                begin
                    phase_next = PH_STOP_B;
                end
            end
            PH_STOP_B:
            begin
                if (pend)
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // bus levels follow the phase reached after this tick
    always_comb
    begin
        res_next.busy_res   = (phase_next != PH_IDLE);
        res_next.done_res   = done;
        res_next.read_byte  = rbyte_next;
        res_next.error_code = err_next;
        case (phase_next)
            PH_START_B:
            begin
                res_next.scl_pull_low = 1'b0;
                res_next.sda_pull_low = 1'b1;
            end
            PH_BIT_LOW:
            begin
                res_next.scl_pull_low = 1'b1;
                res_next.sda_pull_low = !shift_next[7];
            end
            PH_BIT_HIGH:
            begin
                res_next.scl_pull_low = 1'b0;
                res_next.sda_pull_low = !shift_next[7];
            end
            PH_ACK_LOW, PH_RS_LOW, PH_RD_LOW, PH_NACK_LOW:
            begin
                // sda released for the slave, or for a repeated start or nack
                res_next.scl_pull_low = 1'b1;
                res_next.sda_pull_low = 1'b0;
            end
            PH_STOP_A:
            begin
                res_next.scl_pull_low = 1'b1;
                res_next.sda_pull_low = 1'b1;
            end
            PH_STOP_B:
            begin
                res_next.scl_pull_low = 1'b0;
                res_next.sda_pull_low = 1'b1;
            end
            default:
            begin
                res_next.scl_pull_low = 1'b0;
                res_next.sda_pull_low = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_PERIOD_RESET;
            dev_reg  <= DEVICE_SELECT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD:   half_reg <= cfg_data;
                CFG_DEVICE_SELECT: dev_reg  <= cfg_data[DEV_W-1:0];
                default:           ;
            endcase
        end
    end

    // transaction state advances once per accepted tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            shift_reg  <= '0;
            bitcnt_reg <= '0;
            tick_reg   <= '0;
            rd_reg     <= 1'b0;
            addr_reg   <= '0;
            data_reg   <= '0;
            rbyte_reg  <= '0;
            err_reg    <= ERR_OK;
            stage_reg  <= STG_ID;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            bitcnt_reg <= bitcnt_next;
            tick_reg   <= tick_next;
            rd_reg     <= rd_next;
            addr_reg   <= addr_next;
            data_reg   <= data_next;
            rbyte_reg  <= rbyte_next;
            err_reg    <= err_next;
            stage_reg  <= stage_next;
        end
    end

    // result register: refilled in the cycle it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== src/i2cebm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cebm_checker: port level checks of the i2c eeprom byte master
// watches the result channel and the bus levels it reports
// ----------------------------------------------------------------------------
module i2cebm_checker
    import i2cebm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    // a finished transaction no longer reports busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done reported while busy");

    // idle bus lines are released
    a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.busy_res |-> !res.scl_pull_low && !res.sda_pull_low)
        else $error("bus driven while idle");

    // each accepted tick beat yields a result beat in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("accepted beat gave no result");

    // error codes stay in range
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.error_code <= ERR_READ_ID)
        else $error("error code out of range");

endmodule

bind i2c_eeprom_byte_master_core i2cebm_checker u_i2cebm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// ===== verif/tb_i2c_eeprom_byte_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_byte_master_core: regression bench for the i2c eeprom master
// drives one bus tick beat per handshake, predicts every result beat with a
// behavioral copy of the bus engine and compares field by field; a reactive
// slave acks, nacks, stretches and returns read data from the predicted phase
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_byte_master_core;
    import i2cebm_pkg::*;

    // kind value with no command behind it, must act as a plain tick
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // result beats that can be read straight off the spec
    localparam res_t IDLE_RES = '0;
    localparam res_t START_RES = '{scl_pull_low: 1'b0, sda_pull_low: 1'b0,
                                   busy_res: 1'b1, done_res: 1'b0,
                                   read_byte: 8'd0, error_code: ERR_OK};

    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        cmd_t beat;
        bit   pinned;
        res_t want;
    } probe_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    cmd_t              cmd;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [0:0]        cfg_index;
    logic [HALF_W-1:0] cfg_data;

    // copy of the bus engine state, advanced once per accepted tick beat
    logic [HALF_W-1:0] cfg_half;
    logic [DEV_W-1:0]  cfg_dev;
    logic [3:0]        bus_phase;
    logic [7:0]        tx_shift;
    logic [3:0]        tx_bits;
    logic [9:0]        phase_ticks;
    logic              is_read;
    logic [7:0]        addr_hold;
    logic [7:0]        data_hold;
    logic [7:0]        rd_byte;
    logic [2:0]        err_code;
    logic [1:0]        byte_stage;

    // slave behavior for the transfer in flight
    int                nack_plan;   // byte stage that gets a nack, none if above 3
    bit                stretchy;    // slave holds scl low at random in high phases

    res_t              expected_res[$];
    probe_row_t        probe_rows[$];
    int                mismatches = 0;
    int                sent_beats = 0;
    int                taken_beats = 0;
    int                send_gap_max = 0;
    int                recv_gap_max = 0;
    bit                hold_req = 1'b0;

    i2c_eeprom_byte_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // hard stop in case a handshake never completes
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      taken_beats, name, got, want));
    endtask

    // half period zero counts as one tick; a 10-bit value never exceeds the cap
    function automatic logic [9:0] phase_len();
        return (cfg_half == '0) ? 10'd1 : cfg_half;
    endfunction

    // one tick of the phase timer, true on the last tick of the phase;
    // high phases stand still while the slave stretches scl
    function automatic bit phase_end(input bit high_ph, input logic scl_hi);
        if (high_ph && !scl_hi)
            return 1'b0;
        if (int'(phase_ticks) + 1 >= int'(phase_len()))
        begin
            phase_ticks = '0;
            return 1'b1;
        end
        phase_ticks = phase_ticks + 10'd1;
        return 1'b0;
    endfunction

    // advance the engine by one tick beat and build the result beat it causes
    function automatic res_t bus_tick(input cmd_t beat);
        res_t r;
        bit   fin;
        fin = 1'b0;
        case (bus_phase)
            PH_IDLE:
                // kind spare and plain ticks leave the bus idle
                if (beat.kind == KIND_WRITE || beat.kind == KIND_READ)
                begin
                    is_read     = (beat.kind == KIND_READ);
                    addr_hold   = beat.mem_addr;
                    data_hold   = beat.wr_data;
                    byte_stage  = STG_ID;
                    tx_shift    = {cfg_dev, RW_WRITE};
                    tx_bits     = '0;
                    phase_ticks = '0;
                    err_code    = ERR_OK;
                    rd_byte     = '0;
                    bus_phase   = PH_START_A;
                end
            PH_START_A:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_START_B;
            PH_START_B:
                if (phase_end(1'b0, beat.scl_in))
                begin
                    tx_bits   = '0;
                    bus_phase = PH_BIT_LOW;
                end
            PH_BIT_LOW:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_BIT_HIGH;
            PH_BIT_HIGH:
                if (phase_end(1'b1, beat.scl_in))
                begin
                    tx_shift  = {tx_shift[6:0], 1'b0};
                    tx_bits   = tx_bits + 4'd1;
                    bus_phase = (tx_bits >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
                end
            PH_ACK_LOW:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_ACK_HIGH;
            PH_ACK_HIGH:
                if (phase_end(1'b1, beat.scl_in))
                begin
                    tx_bits = '0;
                    if (beat.sda_in)
                    begin
                        // no ack: flag the byte that failed and stop
                        case (byte_stage)
                            STG_ID:   err_code = ERR_ID;
                            STG_ADDR: err_code = ERR_ADDR;
                            STG_DATA: err_code = ERR_DATA;
                            default:  err_code = ERR_READ_ID;
                        endcase
                        rd_byte     = '0;
                        bus_phase   = PH_STOP_A;
                        phase_ticks = '0;
                    end
                    else
                    begin
                        case (byte_stage)
                            STG_ID:
                            begin
                                byte_stage = STG_ADDR;
                                tx_shift   = addr_hold;
                                bus_phase  = PH_BIT_LOW;
                            end
                            STG_ADDR:
                                if (is_read)
                                    bus_phase = PH_RS_LOW;
                                else
                                begin
                                    byte_stage = STG_DATA;
                                    tx_shift   = data_hold;
                                    bus_phase  = PH_BIT_LOW;
                                end
                            STG_DATA:
                            begin
                                bus_phase   = PH_STOP_A;
                                phase_ticks = '0;
                            end
                            default:
                            begin
                                tx_shift  = '0;
                                bus_phase = PH_RD_LOW;
                            end
                        endcase
                    end
                end
            PH_RS_LOW:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_RS_HIGH;
            PH_RS_HIGH:
                if (phase_end(1'b1, beat.scl_in))
                begin
                    byte_stage = STG_READ_ID;
                    tx_shift   = {cfg_dev, RW_READ};
                    bus_phase  = PH_START_B;
                end
            PH_RD_LOW:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_RD_HIGH;
            PH_RD_HIGH:
                if (phase_end(1'b1, beat.scl_in))
                begin
                    tx_shift = {tx_shift[6:0], beat.sda_in};
                    tx_bits  = tx_bits + 4'd1;
                    if (tx_bits >= BITS_PER_BYTE)
                    begin
                        rd_byte   = tx_shift;
                        bus_phase = PH_NACK_LOW;
                    end
                    else
                        bus_phase = PH_RD_LOW;
                end
            PH_NACK_LOW:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_NACK_HIGH;
            PH_NACK_HIGH:
                if (phase_end(1'b1, beat.scl_in))
                begin
                    bus_phase   = PH_STOP_A;
                    phase_ticks = '0;
                end
            PH_STOP_A:
                if (phase_end(1'b0, beat.scl_in))
                    bus_phase = PH_STOP_B;
            PH_STOP_B:
                if (phase_end(1'b0, beat.scl_in))
                begin
                    bus_phase = PH_IDLE;
                    fin       = 1'b1;
                end
            default:
            begin
                bus_phase   = PH_IDLE;
                phase_ticks = '0;
            end
        endcase

        // line drive follows the phase reached after this tick
        r = '0;
        case (bus_phase)
            PH_START_B:
                r.sda_pull_low = 1'b1;
            PH_BIT_LOW:
            begin
                r.scl_pull_low = 1'b1;
                r.sda_pull_low = ~tx_shift[7];
            end
            PH_BIT_HIGH:
                r.sda_pull_low = ~tx_shift[7];
            PH_ACK_LOW, PH_RS_LOW, PH_RD_LOW, PH_NACK_LOW:
                r.scl_pull_low = 1'b1;
            PH_STOP_A:
            begin
                r.scl_pull_low = 1'b1;
                r.sda_pull_low = 1'b1;
            end
            PH_STOP_B:
                r.sda_pull_low = 1'b1;
            default: ;
        endcase
        r.busy_res   = (bus_phase != PH_IDLE);
        r.done_res   = fin;
        r.read_byte  = rd_byte;
        r.error_code = err_code;
        return r;
    endfunction

    // next tick beat from the slave side, reacting to the predicted phase
    function automatic cmd_t next_tick(input bit must_start);
        cmd_t b;
        bit   high_ph;
        bit   last_tick;
        b.mem_addr = 8'($urandom_range(0, 255));
        b.wr_data  = 8'($urandom_range(0, 255));
        b.sda_in   = 1'($urandom_range(0, 1));
        b.scl_in   = 1'($urandom_range(0, 1));
        if (bus_phase == PH_IDLE)
        begin
            if (must_start || $urandom_range(0, 3) != 0)
            begin
                b.kind    = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
                // about one transfer in four runs into a nack somewhere
                nack_plan = must_start ? int'(STG_ID) : $urandom_range(0, 11);
                stretchy  = !must_start && ($urandom_range(0, 2) == 0);
            end
            else
                b.kind = $urandom_range(0, 1) ? KIND_TICK : KIND_SPARE;
        end
        else
        begin
            // commands while busy are noise the block must ignore
            case ($urandom_range(0, 7))
                5:       b.kind = KIND_WRITE;
                6:       b.kind = KIND_READ;
                7:       b.kind = KIND_SPARE;
                default: b.kind = KIND_TICK;
            endcase
        end

        high_ph = (bus_phase == PH_BIT_HIGH) || (bus_phase == PH_ACK_HIGH) ||
                  (bus_phase == PH_RS_HIGH) || (bus_phase == PH_RD_HIGH) ||
                  (bus_phase == PH_NACK_HIGH);
        if (high_ph)
            b.scl_in = stretchy ? ($urandom_range(0, 3) != 0) : 1'b1;

        // ack level only matters on the closing tick of the ack high phase,
        // every tick before it carries junk on sda
        last_tick = b.scl_in && (int'(phase_ticks) + 1 >= int'(phase_len()));
        if (bus_phase == PH_ACK_HIGH && last_tick)
            b.sda_in = (nack_plan == int'(byte_stage));
        return b;
    endfunction

    function automatic void add_probe(input logic [1:0] kind, input logic [7:0] addr,
                                      input logic [7:0] data, input logic sda,
                                      input logic scl, input bit pinned,
                                      input res_t want);
        probe_row_t row;
        row.beat   = '{kind: kind, mem_addr: addr, wr_data: data, sda_in: sda, scl_in: scl};
        row.pinned = pinned;
        row.want   = want;
        probe_rows.push_back(row);
    endfunction

    // offer one tick beat after a random gap and log its expected result
    task automatic send_beat(input cmd_t beat, input bit pinned, input res_t pinned_res);
        int   gap;
        res_t want;
        if (sent_beats % 50 == 0)
            send_gap_max = $urandom_range(0, 1) ? 5 : 0;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= beat;
        do @(posedge clk); while (!cmd_ready);
        want = bus_tick(beat);
        expected_res.push_back(pinned ? pinned_res : want);
        sent_beats++;
    endtask

    // drop valid and hold until every logged result has come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (expected_res.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so back to back writes need one assignment per edge
    task automatic write_reg(input logic [0:0] idx, input logic [HALF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_HALF_PERIOD)
            cfg_half = val;
        else
            cfg_dev = val[DEV_W-1:0];
    endtask

    // one register setting: reprogram while idle, then run random traffic
    // and let the transfer in flight finish so the bus is idle at the end
    task automatic run_setting(input logic [HALF_W-1:0] half, input logic [DEV_W-1:0] dev,
                               input int beats, input bit one_shot, input bit squeeze);
        int         count;
        logic [2:0] pad;
        wait_drained();
        pad = 3'($urandom_range(0, 7));
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_DEVICE_SELECT, {pad, dev});
        cfg_valid <= 1'b0;
        count = 0;
        while (count < beats || bus_phase != PH_IDLE)
        begin
            send_beat(next_tick(one_shot && count == 0), 1'b0, IDLE_RES);
            count++;
            if (squeeze && count == 100)
                hold_req = 1'b1;
            if (squeeze && count == 250)
                wait_drained();
        end
    endtask

    // result side: random ready gaps, one long hold-off on request,
    // and the compare against the oldest logged expectation
    initial
    begin : result_sink
        int   wait_cyc;
        res_t want;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                wait_cyc = HOLD_CYCLES;
            end
            else
            begin
                if (taken_beats % 40 == 0)
                    recv_gap_max = $urandom_range(0, 1) ? 5 : 0;
                wait_cyc = $urandom_range(0, recv_gap_max);
            end
            if (wait_cyc > 0)
            begin
                res_ready <= 1'b0;
                repeat (wait_cyc) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (res_valid !== 1'b1);
            taken_beats++;
            if (expected_res.size() == 0)
                report_mismatch($sformatf("result %0d with nothing expected", taken_beats));
            else
            begin
                want = expected_res.pop_front();
                check_field("scl_pull_low", 8'(res.scl_pull_low), 8'(want.scl_pull_low));
                check_field("sda_pull_low", 8'(res.sda_pull_low), 8'(want.sda_pull_low));
                check_field("busy_res", 8'(res.busy_res), 8'(want.busy_res));
                check_field("done_res", 8'(res.done_res), 8'(want.done_res));
                check_field("read_byte", res.read_byte, want.read_byte);
                check_field("error_code", 8'(res.error_code), 8'(want.error_code));
            end
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= '0;

        // model state after reset
        cfg_half    = HALF_PERIOD_RESET;
        cfg_dev     = DEVICE_SELECT_RESET;
        bus_phase   = PH_IDLE;
        tx_shift    = '0;
        tx_bits     = '0;
        phase_ticks = '0;
        is_read     = 1'b0;
        addr_hold   = '0;
        data_hold   = '0;
        rd_byte     = '0;
        err_code    = ERR_OK;
        byte_stage  = STG_ID;
        nack_plan   = 99;
        stretchy    = 1'b0;

        // directed rows at reset settings: idle ticks, spare kind,
        // a write with the widest fields, then commands while busy
        add_probe(KIND_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 1'b1, IDLE_RES);
        add_probe(KIND_SPARE, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1, IDLE_RES);
        add_probe(KIND_TICK,  8'hff, 8'h00, 1'b1, 1'b0, 1'b1, IDLE_RES);
        add_probe(KIND_TICK,  8'h00, 8'hff, 1'b0, 1'b1, 1'b1, IDLE_RES);
        add_probe(KIND_WRITE, 8'hff, 8'h00, 1'b0, 1'b1, 1'b1, START_RES);
        add_probe(KIND_READ,  8'h00, 8'hff, 1'b1, 1'b1, 1'b1, START_RES);
        add_probe(KIND_WRITE, 8'haa, 8'h55, 1'b0, 1'b0, 1'b1, START_RES);
        add_probe(KIND_SPARE, 8'h55, 8'haa, 1'b1, 1'b0, 1'b1, START_RES);
        add_probe(KIND_TICK,  8'h01, 8'h80, 1'b0, 1'b0, 1'b1, START_RES);
        add_probe(KIND_TICK,  8'h80, 8'h01, 1'b1, 1'b1, 1'b1, START_RES);
        add_probe(KIND_READ,  8'hff, 8'hff, 1'b0, 1'b0, 1'b1, START_RES);
        add_probe(KIND_TICK,  8'h7f, 8'hfe, 1'b1, 1'b0, 1'b1, START_RES);
        add_probe(KIND_WRITE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, IDLE_RES);
        add_probe(KIND_TICK,  8'h3c, 8'hc3, 1'b0, 1'b1, 1'b0, IDLE_RES);
        add_probe(KIND_SPARE, 8'hc3, 8'h3c, 1'b1, 1'b1, 1'b0, IDLE_RES);
        add_probe(KIND_TICK,  8'h0f, 8'hf0, 1'b0, 1'b0, 1'b0, IDLE_RES);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < probe_rows.size(); i++)
            send_beat(probe_rows[i].beat, probe_rows[i].pinned, probe_rows[i].want);

        // finish the directed write: slave stretches and refuses the id byte
        nack_plan = int'(STG_ID);
        stretchy  = 1'b1;
        while (bus_phase != PH_IDLE)
            send_beat(next_tick(1'b0), 1'b0, IDLE_RES);

        // random traffic across settings; the first one backs the block up
        run_setting(10'd1, 7'($urandom_range(0, 127)), 260, 1'b0, 1'b1);
        run_setting(10'd0, 7'd127, 80, 1'b0, 1'b0);
        run_setting(10'd2, 7'd0, 80, 1'b0, 1'b0);
        run_setting(10'd3, 7'($urandom_range(0, 127)), 60, 1'b0, 1'b0);
        run_setting(10'd1, 7'($urandom_range(0, 127)), 50, 1'b0, 1'b0);

        // bounded drain, then a few idle cycles to catch stray results
        cmd_valid <= 1'b0;
        repeat (2000)
        begin
            if (expected_res.size() == 0)
                break;
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (expected_res.size() != 0)
            report_mismatch($sformatf("%0d expected results never came",
                                      expected_res.size()));

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
src/i2cebm_pkg.sv
src/i2c_eeprom_byte_master_core.sv
src/i2cebm_checker.sv
verif/tb_i2c_eeprom_byte_master_core.sv
